@@ design/armg_pkg.sv @@
// Shared constants, types and CORDIC tables for the axis rotation matrix generator.
package armg_pkg;

  // Field widths and arithmetic format
  localparam int ANGLE_BITS    = 16;
  localparam int FRAC_BITS     = 14;
  localparam int CORDIC_STAGES = 16;
  localparam int ELEM_BITS     = FRAC_BITS + 2;
  localparam int INT_FRAC      = 30;
  localparam int CW            = 32;
  localparam int STAGE_W       = 5;
  localparam int ROUND_SH      = INT_FRAC - FRAC_BITS;
  localparam int ROWS          = 4;

  // Axis codes
  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  // Reciprocal of the CORDIC gain in Q.30
  localparam logic signed [CW-1:0] CORDIC_K = 32'sd652032874;
  localparam logic signed [CW-1:0] QUARTER  = 32'sh40000000;
  localparam logic [CW-1:0]        HALF     = 32'h80000000;

  // Rotation angle of each stage, full turn = 2^32
  localparam logic signed [CW-1:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Data carried from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
    logic [1:0]           op;
  } cordic_t;

  // Round a Q.30 value to the element format, negate on request, clamp to +/-1.0
  function automatic logic signed [ELEM_BITS-1:0] to_elem(input logic signed [CW-1:0] v,
                                                          input logic neg);
    logic signed [CW+1:0] rnd;
    logic signed [CW+1:0] one;
    logic signed [CW+1:0] r;
    rnd = (CW+2)'((64'd1 << ROUND_SH) >> 1);
    one = (CW+2)'(64'd1 << FRAC_BITS);
    r   = ((CW+2)'(v) + rnd) >>> ROUND_SH;
    if (neg) begin
      r = -r;
    end
    if (r > one) begin
      r = one;
    end
    if (r < -one) begin
      r = -one;
    end
    return r[ELEM_BITS-1:0];
  endfunction

endpackage

@@ design/axis_rotation_matrix_gen.sv @@
// Top level: CORDIC cell chain plus row sequencer producing 4x4 axis rotation matrices.
//
//  channel   direction  handshake              fields
//  command   in         start & !busy          op[1:0], angle[15:0]
//  result    out        valid                  row_index, elem0..elem3, last
//
// Busy is raised by a gap counter after each item with a real axis, and no new item
// is taken while it is high; this spaces items for the four-row output sequencer.
// From accept to row 0 an item passes the fold register, the cell chain, the rounding
// register, the sequencer load and the row register; rows follow on consecutive
// cycles.
// An item with axis code 3 is taken and dropped without raising busy.
// Reset is synchronous; it clears the valid bits of the chain and the sequencer.
// The receiver cannot stall, so results are never held back.
module axis_rotation_matrix_gen (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            op,
  input  logic signed [armg_pkg::ANGLE_BITS-1:0] angle,
  output logic                                  valid,
  output logic [1:0]                            row_index,
  output logic signed [armg_pkg::ELEM_BITS-1:0]  elem0,
  output logic signed [armg_pkg::ELEM_BITS-1:0]  elem1,
  output logic signed [armg_pkg::ELEM_BITS-1:0]  elem2,
  output logic signed [armg_pkg::ELEM_BITS-1:0]  elem3,
  output logic                                  last
);
  import armg_pkg::*;

  logic                        accept;
  logic                        take;
  logic [1:0]                  gap;
  logic signed [CW-1:0]        z_in;
  cordic_t                     head_next;
  logic                        head_valid;
  cordic_t                     head_data;
  logic                        chain_valid [CORDIC_STAGES+1];
  cordic_t                     chain_data  [CORDIC_STAGES+1];
  logic                        out_load;
  logic [1:0]                  out_op;
  logic signed [ELEM_BITS-1:0] out_sin;
  logic signed [ELEM_BITS-1:0] out_cos;

  assign accept = start && !busy;
  assign take   = accept && (op != AXIS_NONE);
  assign busy   = (gap != 2'd0);

  // Space items apart by holding busy after each taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (take) begin
      gap <= 2'(ROWS - 1);
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  // Widen the angle and fold it into the right half plane
  always_comb begin
    z_in              = CW'(angle) <<< (CW - ANGLE_BITS);
    head_next.x       = CORDIC_K;
    head_next.y       = '0;
    head_next.op      = op;
    head_next.z       = z_in;
    head_next.flip    = 1'b0;
    if ((z_in > QUARTER) || (z_in < -QUARTER)) begin
      head_next.z    = z_in + HALF;
      head_next.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    head_data <= head_next;
  end

  assign chain_valid[0] = head_valid;
  assign chain_data[0]  = head_data;

  // Chain of rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    armg_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage     (STAGE_W'(i)),
      .valid_in  (chain_valid[i]),
      .data_in   (chain_data[i]),
      .valid_out (chain_valid[i+1]),
      .data_out  (chain_data[i+1])
    );
  end

  // Round and clamp sine and cosine
  always_ff @(posedge clk) begin
    if (rst) begin
      out_load <= 1'b0;
    end else begin
      out_load <= chain_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_op  <= chain_data[CORDIC_STAGES].op;
    out_sin <= to_elem(chain_data[CORDIC_STAGES].y, chain_data[CORDIC_STAGES].flip);
    out_cos <= to_elem(chain_data[CORDIC_STAGES].x, chain_data[CORDIC_STAGES].flip);
  end

  armg_row_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (out_load),
    .load_op   (out_op),
    .load_sin  (out_sin),
    .load_cos  (out_cos),
    .valid     (valid),
    .row_index (row_index),
    .elem0     (elem0),
    .elem1     (elem1),
    .elem2     (elem2),
    .elem3     (elem3),
    .last      (last)
  );

endmodule

@@ design/armg_cordic_cell.sv @@
// One CORDIC rotation cell of the chain.
module armg_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [armg_pkg::STAGE_W-1:0]  stage,
  input  logic                          valid_in,
  input  armg_pkg::cordic_t             data_in,
  output logic                          valid_out,
  output armg_pkg::cordic_t             data_out
);
  import armg_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] da;
  cordic_t              data_next;

  // Rotate toward zero residual angle
  always_comb begin
    dx        = data_in.y >>> stage;
    dy        = data_in.x >>> stage;
    da        = ATAN_TURN[stage];
    data_next = data_in;
    if (!data_in.z[CW-1]) begin
      data_next.x = data_in.x - dx;
      data_next.y = data_in.y + dy;
      data_next.z = data_in.z - da;
    end else begin
      data_next.x = data_in.x + dx;
      data_next.y = data_in.y - dy;
      data_next.z = data_in.z + da;
    end
  end

  // Hand the item to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

@@ design/armg_row_emit.sv @@
// Row sequencer: turns one sine/cosine pair into four matrix rows.
module armg_row_emit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [1:0]                           load_op,
  input  logic signed [armg_pkg::ELEM_BITS-1:0] load_sin,
  input  logic signed [armg_pkg::ELEM_BITS-1:0] load_cos,
  output logic                                 valid,
  output logic [1:0]                           row_index,
  output logic signed [armg_pkg::ELEM_BITS-1:0] elem0,
  output logic signed [armg_pkg::ELEM_BITS-1:0] elem1,
  output logic signed [armg_pkg::ELEM_BITS-1:0] elem2,
  output logic signed [armg_pkg::ELEM_BITS-1:0] elem3,
  output logic                                 last
);
  import armg_pkg::*;

  localparam logic signed [ELEM_BITS-1:0] ONE  = ELEM_BITS'(64'd1 << FRAC_BITS);
  localparam logic signed [ELEM_BITS-1:0] ZERO = '0;

  logic                         active;
  logic [1:0]                   row;
  logic [1:0]                   op_q;
  logic signed [ELEM_BITS-1:0]  s_q;
  logic signed [ELEM_BITS-1:0]  c_q;
  logic signed [ELEM_BITS-1:0]  e_next [4];

  // Build the current row from the identity and the axis pattern
  always_comb begin
    e_next[0] = ZERO;
    e_next[1] = ZERO;
    e_next[2] = ZERO;
    e_next[3] = ZERO;
    e_next[row] = ONE;
    case (op_q)
      AXIS_X: begin
        if (row == 2'd1) begin
          e_next[1] = c_q;
          e_next[2] = -s_q;
        end else if (row == 2'd2) begin
          e_next[1] = s_q;
          e_next[2] = c_q;
        end
      end
      AXIS_Y: begin
        if (row == 2'd0) begin
          e_next[0] = c_q;
          e_next[2] = s_q;
        end else if (row == 2'd2) begin
          e_next[0] = -s_q;
          e_next[2] = c_q;
        end
      end
      default: begin
        if (row == 2'd0) begin
          e_next[0] = c_q;
          e_next[1] = -s_q;
        end else if (row == 2'd1) begin
          e_next[0] = s_q;
          e_next[1] = c_q;
        end
      end
    endcase
  end

  // Advance the row counter, take a new item when it arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
      valid  <= 1'b0;
    end else begin
      valid <= active;
      if (load) begin
        active <= 1'b1;
        row    <= '0;
      end else if (active) begin
        row <= row + 2'd1;
        if (row == 2'(ROWS - 1)) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Hold item data and register the outgoing row
  always_ff @(posedge clk) begin
    if (load) begin
      op_q <= load_op;
      s_q  <= load_sin;
      c_q  <= load_cos;
    end
    row_index <= row;
    elem0     <= e_next[0];
    elem1     <= e_next[1];
    elem2     <= e_next[2];
    elem3     <= e_next[3];
    last      <= (row == 2'(ROWS - 1));
  end

endmodule

@@ design/armg_checker.sv @@
// Port-level checks for the axis rotation matrix generator, bound to the top level.
module armg_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       valid,
  input logic [1:0] row_index,
  input logic       last
);
  import armg_pkg::*;

  // Busy is raised after an item with a real axis is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (op != AXIS_NONE) |=> busy)
    else $error("busy not raised after an item was taken");

  // Rows of one matrix come out in order on consecutive cycles
  a_row_0_1: assert property (@(posedge clk) disable iff (rst)
    valid && (row_index == 2'd0) |=> valid && (row_index == 2'd1))
    else $error("row 1 did not follow row 0");

  a_row_1_2: assert property (@(posedge clk) disable iff (rst)
    valid && (row_index == 2'd1) |=> valid && (row_index == 2'd2))
    else $error("row 2 did not follow row 1");

  a_row_2_3: assert property (@(posedge clk) disable iff (rst)
    valid && (row_index == 2'd2) |=> valid && (row_index == 2'd3) && last)
    else $error("row 3 did not follow row 2 or was not marked last");

  // Last marks only the final row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> (row_index == 2'd3))
    else $error("last set on a row other than row 3");

endmodule

bind axis_rotation_matrix_gen armg_checker u_armg_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .valid     (valid),
  .row_index (row_index),
  .last      (last)
);
